@@ sv/oli_pkg.sv @@
// package: shared types and constants for the ordered list block
package oli_pkg;

	// default list capacity
	localparam int LIST_DEPTH = 16;

	// width of a stored value
	localparam int VALUE_W = 32;

	// request opcodes; code 3 is unused and ignored
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2
	} mode_t;

	// result status codes
	typedef enum logic [2:0] {
		STATUS_DONE     = 3'd0,
		STATUS_NO_MATCH = 3'd1,
		STATUS_FULL     = 3'd2,
		STATUS_ENTRY    = 3'd3,
		STATUS_EMPTY    = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} state_t;

	// request payload
	typedef struct packed {
		mode_t                     mode;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	// result payload
	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] entry_value;
		logic                      last;
	} result_t;

endpackage

@@ sv/oli_mem.sv @@
// module: list entry storage, one write port and one registered read port
module oli_mem #(
	parameter int DEPTH = oli_pkg::LIST_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [oli_pkg::VALUE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [oli_pkg::VALUE_W-1:0] rd_data
);

	logic [oli_pkg::VALUE_W-1:0] mem_q [DEPTH];
	logic [oli_pkg::VALUE_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/oli_seq.sv @@
// module: sequencer with shared index and compare unit for the ordered list
module oli_seq #(
	parameter int DEPTH = oli_pkg::LIST_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  oli_pkg::cmd_t               cmd,
	output logic                        strobe,
	output oli_pkg::result_t            result,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [oli_pkg::VALUE_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [oli_pkg::VALUE_W-1:0] rd_data
);

	oli_pkg::state_t             state_q, state_d;
	logic [AW-1:0]               idx_q, idx_d;
	logic [AW-1:0]               dst_q, dst_d;
	logic [CW-1:0]               count_q, count_d;
	logic [oli_pkg::VALUE_W-1:0] value_q;
	logic                        strobe_q;
	oli_pkg::result_t            result_q;

	logic                        accept;
	logic [CW-1:0]               idx_inc;
	logic                        more;
	logic                        match;
	logic                        full;
	logic                        emit;
	oli_pkg::result_t            emit_res;

	assign busy   = (state_q != oli_pkg::ST_IDLE);
	assign accept = start && !busy;

	// shared unit: index step, bound check and value compare
	assign idx_inc = CW'(idx_q) + CW'(1);
	assign more    = (idx_inc < count_q);
	assign match   = (rd_data == value_q);
	assign full    = (count_q == CW'(DEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			oli_pkg::ST_IDLE: begin
				if (accept && (count_q != '0)) begin
					case (cmd.mode)
						oli_pkg::MODE_DELETE: state_d = oli_pkg::ST_SCAN_RD;
						oli_pkg::MODE_DUMP:   state_d = oli_pkg::ST_DUMP_RD;
						default:              state_d = oli_pkg::ST_IDLE;
					endcase
				end
			end
			oli_pkg::ST_SCAN_RD:  state_d = oli_pkg::ST_SCAN_CMP;
			oli_pkg::ST_SCAN_CMP: begin
				if (match) begin
					state_d = more ? oli_pkg::ST_SHIFT_RD : oli_pkg::ST_IDLE;
				end else begin
					state_d = more ? oli_pkg::ST_SCAN_RD : oli_pkg::ST_IDLE;
				end
			end
			oli_pkg::ST_SHIFT_RD: state_d = oli_pkg::ST_SHIFT_WR;
			oli_pkg::ST_SHIFT_WR: state_d = more ? oli_pkg::ST_SHIFT_RD : oli_pkg::ST_IDLE;
			oli_pkg::ST_DUMP_RD:  state_d = oli_pkg::ST_DUMP_OUT;
			oli_pkg::ST_DUMP_OUT: state_d = more ? oli_pkg::ST_DUMP_RD : oli_pkg::ST_IDLE;
			default:              state_d = oli_pkg::ST_IDLE;
		endcase
	end

	// datapath controls and results
	always_comb begin
		idx_d                = idx_q;
		dst_d                = dst_q;
		count_d              = count_q;
		wr_en                = 1'b0;
		wr_addr              = dst_q;
		wr_data              = rd_data;
		rd_en                = 1'b0;
		rd_addr              = idx_q;
		emit                 = 1'b0;
		emit_res.status      = oli_pkg::STATUS_DONE;
		emit_res.entry_value = '0;
		emit_res.last        = 1'b1;
		case (state_q)
			oli_pkg::ST_IDLE: begin
				idx_d = '0;
				if (accept) begin
					case (cmd.mode)
						oli_pkg::MODE_INSERT: begin
							emit = 1'b1;
							if (full) begin
								emit_res.status = oli_pkg::STATUS_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_data = cmd.value;
								count_d = count_q + CW'(1);
							end
						end
						oli_pkg::MODE_DELETE: begin
							if (count_q == '0) begin
								emit            = 1'b1;
								emit_res.status = oli_pkg::STATUS_NO_MATCH;
							end
						end
						oli_pkg::MODE_DUMP: begin
							if (count_q == '0) begin
								emit            = 1'b1;
								emit_res.status = oli_pkg::STATUS_EMPTY;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			oli_pkg::ST_SCAN_RD: begin
				rd_en = 1'b1;
			end
			oli_pkg::ST_SCAN_CMP: begin
				if (match) begin
					if (more) begin
						dst_d = idx_q;
						idx_d = idx_inc[AW-1:0];
					end else begin
						count_d = count_q - CW'(1);
						emit    = 1'b1;
					end
				end else if (more) begin
					idx_d = idx_inc[AW-1:0];
				end else begin
					emit            = 1'b1;
					emit_res.status = oli_pkg::STATUS_NO_MATCH;
				end
			end
			oli_pkg::ST_SHIFT_RD: begin
				rd_en = 1'b1;
			end
			oli_pkg::ST_SHIFT_WR: begin
				wr_en = 1'b1;
				if (more) begin
					dst_d = idx_q;
					idx_d = idx_inc[AW-1:0];
				end else begin
					count_d = count_q - CW'(1);
					emit    = 1'b1;
				end
			end
			oli_pkg::ST_DUMP_RD: begin
				rd_en = 1'b1;
			end
			oli_pkg::ST_DUMP_OUT: begin
				emit                 = 1'b1;
				emit_res.status      = oli_pkg::STATUS_ENTRY;
				emit_res.entry_value = rd_data;
				emit_res.last        = !more;
				if (more) begin
					idx_d = idx_inc[AW-1:0];
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= oli_pkg::ST_IDLE;
			idx_q    <= '0;
			dst_q    <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			dst_q    <= dst_d;
			count_q  <= count_d;
			strobe_q <= emit;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= cmd.value;
		end
		if (emit) begin
			result_q <= emit_res;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

@@ sv/ordered_list_insert_delete.sv @@
// module: top level of the bounded ordered list with insert, delete and dump
//
// A request is taken when start is high and busy is low. An insert finishes in
// the cycle it is taken (busy stays low) and its status is strobed in the next
// cycle. A delete walks the list head first through the single read port of
// the entry memory. It reads and compares each entry up to the match, then
// reads each later entry and moves it up one place to close the gap. Each
// entry is either compared or moved, never both. A dump reads each entry and
// then gives it as a result. The registered memory read puts a read state
// before each compare, move or result. Every result is on the result port for
// exactly one cycle with strobe high; the receiver cannot stall, so it must
// take each one. The final result of a request has last set.
module ordered_list_insert_delete #(
	parameter int LIST_DEPTH = oli_pkg::LIST_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  oli_pkg::cmd_t    cmd,
	output logic             strobe,
	output oli_pkg::result_t result
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [oli_pkg::VALUE_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [oli_pkg::VALUE_W-1:0] rd_data;

	// sequencer
	oli_seq #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.strobe  (strobe),
		.result  (result),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// entry storage
	oli_mem #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

`ifndef ASSERT_OFF
	// an insert always answers in the next cycle with a final result
	a_insert_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.mode == oli_pkg::MODE_INSERT) |=> strobe && result.last)
		else $error("insert did not answer in the next cycle");

	// only list entries carry a value and can be non-final
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.status != oli_pkg::STATUS_ENTRY) |->
		result.last && (result.entry_value == '0))
		else $error("status result not final or carries a value");

	// the final result of a request leaves the block ready
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("busy after final result");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: ordered list block checked against a queue-based prediction of its contents
module testbench;

	localparam int DEPTH       = oli_pkg::LIST_DEPTH;
	localparam int RAND_ITEMS  = 234;
	localparam int CALM_TAIL   = 40;
	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_SHOWN   = 10;

	// opcode the block takes but ignores
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	logic             busy;
	oli_pkg::cmd_t    cmd    = '0;
	logic             strobe;
	oli_pkg::result_t result;

	oli_pkg::cmd_t                      queued_reqs[$];
	oli_pkg::result_t                   due_results[$];
	logic signed [oli_pkg::VALUE_W-1:0] list_contents[$];
	logic signed [oli_pkg::VALUE_W-1:0] recent_vals[DEPTH];

	int   recent_n       = 0;
	int   recent_wr      = 0;
	int   total_reqs     = 0;
	int   sent_reqs      = 0;
	int   taken_reqs     = 0;
	int   calm_from      = 0;
	int   gap_left       = 0;
	int   cycle_count    = 0;
	int   mismatch_count = 0;
	logic req_taken      = 1'b0;

	ordered_list_insert_delete #(
		.LIST_DEPTH(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.result(result)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// list prediction: updates the expected contents and queues the results
	function automatic void apply_list_op(oli_pkg::cmd_t c);
		oli_pkg::result_t r;
		int               hit;
		r      = '0;
		r.last = 1'b1;
		hit    = -1;
		case (c.mode)
		oli_pkg::MODE_INSERT: begin
			if (list_contents.size() >= DEPTH) begin
				r.status = oli_pkg::STATUS_FULL;
			end else begin
				list_contents.push_back(c.value);
				r.status = oli_pkg::STATUS_DONE;
			end
			due_results.push_back(r);
		end
		oli_pkg::MODE_DELETE: begin
			for (int i = 0; i < list_contents.size(); i++) begin
				if (hit < 0 && list_contents[i] == c.value) hit = i;
			end
			if (hit >= 0) begin
				list_contents.delete(hit);
				r.status = oli_pkg::STATUS_DONE;
			end else begin
				r.status = oli_pkg::STATUS_NO_MATCH;
			end
			due_results.push_back(r);
		end
		oli_pkg::MODE_DUMP: begin
			if (list_contents.size() == 0) begin
				r.status = oli_pkg::STATUS_EMPTY;
				due_results.push_back(r);
			end else begin
				for (int i = 0; i < list_contents.size(); i++) begin
					r.status      = oli_pkg::STATUS_ENTRY;
					r.entry_value = list_contents[i];
					r.last        = (i == list_contents.size() - 1);
					due_results.push_back(r);
				end
			end
		end
		default: begin
			// unused opcode, no result and no change
		end
		endcase
	endfunction

	// values weighted toward the extremes
	function automatic logic signed [oli_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 15))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return '0;
		3: return '1;
		4: return 32'd1;
		default: return $urandom;
		endcase
	endfunction

	// add a request and remember inserted values as delete targets
	task automatic queue_req(input logic [1:0] m,
			input logic signed [oli_pkg::VALUE_W-1:0] v);
		oli_pkg::cmd_t c;
		c.mode  = oli_pkg::mode_t'(m);
		c.value = v;
		queued_reqs.push_back(c);
		if (m == oli_pkg::MODE_INSERT) begin
			recent_vals[recent_wr] = v;
			recent_wr = (recent_wr + 1) % DEPTH;
			if (recent_n < DEPTH) recent_n++;
		end
	endtask

	// stimulus, reset and end of run
	initial begin
		logic signed [oli_pkg::VALUE_W-1:0] tail_v;
		logic signed [oli_pkg::VALUE_W-1:0] dv;
		int                                 counted;
		int                                 phase_left;
		int                                 r;
		logic                               grow;

		// empty list, unused opcode, extremes, duplicates, full list, head and tail deletes
		queue_req(oli_pkg::MODE_DUMP, '0);
		queue_req(oli_pkg::MODE_DELETE, 32'd5);
		queue_req(MODE_UNUSED, 32'h7fff_ffff);
		queue_req(oli_pkg::MODE_INSERT, 32'h8000_0000);
		queue_req(oli_pkg::MODE_INSERT, 32'h7fff_ffff);
		queue_req(oli_pkg::MODE_INSERT, '0);
		queue_req(oli_pkg::MODE_INSERT, '1);
		queue_req(oli_pkg::MODE_INSERT, 32'h7fff_ffff);
		tail_v = '0;
		for (int i = 5; i < DEPTH; i++) begin
			tail_v = $urandom;
			queue_req(oli_pkg::MODE_INSERT, tail_v);
		end
		queue_req(oli_pkg::MODE_INSERT, 32'h5555_aaaa);
		queue_req(oli_pkg::MODE_DUMP, $urandom);
		queue_req(oli_pkg::MODE_DELETE, 32'h7fff_ffff);
		queue_req(oli_pkg::MODE_DELETE, 32'h8000_0000);
		queue_req(oli_pkg::MODE_DELETE, tail_v);
		queue_req(oli_pkg::MODE_DELETE, 32'h5555_aaaa);
		queue_req(oli_pkg::MODE_DUMP, '0);

		// random mix in alternating grow and shrink phases
		counted    = 0;
		grow       = 1'b1;
		phase_left = $urandom_range(20, 50);
		while (counted < RAND_ITEMS) begin
			if (phase_left == 0) begin
				grow       = !grow;
				phase_left = $urandom_range(20, 50);
			end
			phase_left--;
			r = $urandom_range(0, 99);
			if (r < (grow ? 55 : 20)) begin
				queue_req(oli_pkg::MODE_INSERT, pick_value());
				counted++;
			end else if (r < 75) begin
				if (recent_n > 0 && $urandom_range(0, 9) < 7)
					dv = recent_vals[$urandom_range(0, recent_n - 1)];
				else
					dv = pick_value();
				queue_req(oli_pkg::MODE_DELETE, dv);
				counted++;
			end else if (r < 96) begin
				queue_req(oli_pkg::MODE_DUMP, $urandom);
				counted++;
			end else begin
				queue_req(MODE_UNUSED, $urandom);
			end
		end
		total_reqs = queued_reqs.size();
		calm_from  = total_reqs - CALM_TAIL;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (taken_reqs == total_reqs);
		wait (due_results.size() == 0);
		repeat (4 * DEPTH + 40) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0) begin
			$display("ordered_list_insert_delete: match");
		end else begin
			$display("ordered_list_insert_delete: mismatch");
		end
		$finish;
	end

	// request driver: holds each request until taken, with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !req_taken) begin
			// request still waiting for the block
		end else if (gap_left > 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (queued_reqs.size() == 0) begin
			start <= 1'b0;
		end else if (sent_reqs < calm_from && $urandom_range(0, 4) == 0) begin
			start    <= 1'b0;
			gap_left <= $urandom_range(0, 7);
		end else begin
			cmd       <= queued_reqs.pop_front();
			start     <= 1'b1;
			sent_reqs <= sent_reqs + 1;
		end
	end

	// monitor: predicts on each taken request, checks each strobed result
	always @(posedge clk) begin
		oli_pkg::result_t want;
		cycle_count <= cycle_count + 1;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= start && !busy;
			if (start && !busy) begin
				apply_list_op(cmd);
				taken_reqs <= taken_reqs + 1;
			end
			if (strobe) begin
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("ERROR: unexpected result status=%0d value=%0d last=%0b",
							result.status, result.entry_value, result.last);
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status ||
							result.entry_value !== want.entry_value ||
							result.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= MAX_SHOWN)
							$display({"ERROR: expected status=%0d value=%0d last=%0b,",
								" got status=%0d value=%0d last=%0b"},
								want.status, want.entry_value, want.last,
								result.status, result.entry_value, result.last);
					end
				end
			end
		end
	end

	// timeout
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("ordered_list_insert_delete: mismatch");
		$finish;
	end

endmodule
